// File: src/plt_pkg.sv
package plt_pkg;

    // Field widths of the stream payloads.
    localparam int TIME_W     = 40;
    localparam int AGE_W      = 41;
    localparam int COUNT_W    = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 136;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int TMO_W      = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUBIOUS_TMO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_TMO     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE_TMO = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_MISSED_RST   = 8'd3;
    localparam logic [TMO_W-1:0]   DUBIOUS_TMO_RST  = 20'd900;
    localparam logic [TMO_W-1:0]   GOOD_TMO_RST     = 20'd900;
    localparam logic [TMO_W-1:0]   INACTIVE_TMO_RST = 20'd0;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 8'hFF;

    // Commands; codes above CMD_QUERY behave as a query.
    typedef enum logic [3:0] {
        CMD_CREATE     = 4'd0,
        CMD_REMOVE     = 4'd1,
        CMD_SEEN       = 4'd2,
        CMD_REPLY_TIME = 4'd3,
        CMD_PING_TIME  = 4'd4,
        CMD_PINGED     = 4'd5,
        CMD_REPLIED    = 4'd6,
        CMD_FAILED     = 4'd7,
        CMD_RESET_CNT  = 4'd8,
        CMD_SET_STATE  = 4'd9,
        CMD_QUERY      = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_DUBIOUS = 2'd1,
        ST_GOOD    = 2'd2,
        ST_BAD     = 2'd3
    } t_live_state;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]        pad;
        t_live_state       forced_state;
        logic [TIME_W-1:0] now_seconds;
        t_cmd              cmd;
    } t_item;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic signed [AGE_W-1:0] ping_span;
        logic signed [AGE_W-1:0] reply_span;
        logic [TIME_W-1:0]       peer_age;
        logic                    expired;
        logic                    ping_due;
        logic                    timed_out;
        logic [COUNT_W-1:0]      missed_pings;
        t_live_state             peer_state;
        logic                    present;
    } t_result;

    typedef struct packed {
        logic [COUNT_W-1:0] max_missed;
        logic [TMO_W-1:0]   dubious_tmo;
        logic [TMO_W-1:0]   good_tmo;
        logic [TMO_W-1:0]   inactive_tmo;
    } t_cfg;

    // Control part of the peer record.
    typedef struct packed {
        logic               valid;
        t_live_state        state;
        logic [COUNT_W-1:0] count;
    } t_peer_ctl;

endpackage

// File: src/plt_state.sv
module plt_state import plt_pkg::*; #(
    parameter int TW = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_cmd               i_cmd,
    input  logic [TW-1:0]      i_now,
    input  t_live_state        i_forced,
    input  logic [COUNT_W-1:0] i_max_missed,
    output t_peer_ctl          o_ctl,
    output logic [TW-1:0]      o_first,
    output logic [TW-1:0]      o_seen,
    output logic [TW-1:0]      o_reply,
    output logic [TW-1:0]      o_ping
);

    t_peer_ctl          r_ctl,   n_ctl;
    logic [TW-1:0]      r_first, n_first;
    logic [TW-1:0]      r_seen,  n_seen;
    logic [TW-1:0]      r_reply, n_reply;
    logic [TW-1:0]      r_ping,  n_ping;
    logic [COUNT_W-1:0] w_bumped;

    // Missed-ping count plus one, held at saturation.
    assign w_bumped = (r_ctl.count == COUNT_SAT) ? r_ctl.count : r_ctl.count + 1'b1;

    // Apply the command to the current record.
    always_comb begin
        n_ctl   = r_ctl;
        n_first = r_first;
        n_seen  = r_seen;
        n_reply = r_reply;
        n_ping  = r_ping;
        if (i_cmd == CMD_CREATE) begin
            n_ctl.valid = 1'b1;
            n_ctl.state = ST_UNKNOWN;
            n_ctl.count = '0;
            n_first     = i_now;
            n_seen      = i_now;
            n_reply     = '0;
            n_ping      = '0;
        end else if (r_ctl.valid) begin
            unique case (i_cmd)
                CMD_REMOVE:     n_ctl.valid = 1'b0;
                CMD_SEEN:       n_seen = i_now;
                CMD_REPLY_TIME: n_reply = i_now;
                CMD_PING_TIME:  n_ping = i_now;
                CMD_PINGED: begin
                    n_ping      = i_now;
                    n_ctl.count = w_bumped;
                    if (r_ctl.state == ST_UNKNOWN || r_ctl.state == ST_GOOD) begin
                        n_ctl.state = ST_DUBIOUS;
                    end else if (r_ctl.state == ST_DUBIOUS && w_bumped >= i_max_missed) begin
                        n_ctl.state = ST_BAD;
                    end
                end
                CMD_REPLIED: begin
                    n_reply     = i_now;
                    n_seen      = i_now;
                    n_ctl.count = '0;
                    n_ctl.state = ST_GOOD;
                end
                CMD_FAILED: begin
                    n_ctl.count = w_bumped;
                    if (w_bumped >= i_max_missed) begin
                        n_ctl.state = ST_BAD;
                    end
                end
                CMD_RESET_CNT:  n_ctl.count = '0;
                CMD_SET_STATE: begin
                    n_ctl.state = i_forced;
                    if (i_forced == ST_GOOD) begin
                        n_ctl.count = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Record registers; time stamps are always written by create first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, state: ST_UNKNOWN, count: '0};
        end else if (i_fire) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_first <= n_first;
            r_seen  <= n_seen;
            r_reply <= n_reply;
            r_ping  <= n_ping;
        end
    end

    assign o_ctl   = n_ctl;
    assign o_first = n_first;
    assign o_seen  = n_seen;
    assign o_reply = n_reply;
    assign o_ping  = n_ping;

endmodule

// File: src/plt_report.sv
module plt_report import plt_pkg::*; #(
    parameter int TW = 40
) (
    input  t_peer_ctl     i_ctl,
    input  logic [TW-1:0] i_first,
    input  logic [TW-1:0] i_seen,
    input  logic [TW-1:0] i_reply,
    input  logic [TW-1:0] i_ping,
    input  logic [TW-1:0] i_now,
    input  t_cfg          i_cfg,
    output t_result       o_result
);

    logic [TW-1:0] w_last;
    logic [TW-1:0] w_first_diff;
    logic [TW-1:0] w_reply_diff;
    logic [TW-1:0] w_ping_diff;
    logic          w_bad;

    // True when now is not before the stamp and at least limit seconds on.
    function automatic logic f_elapsed(input logic [TW-1:0] now,
                                       input logic [TW-1:0] stamp,
                                       input logic [TW-1:0] limit);
        return (now >= stamp) && ((now - stamp) >= limit);
    endfunction

    // Idle reference falls back to the creation time when never seen.
    assign w_last       = (i_seen != '0) ? i_seen : i_first;
    assign w_first_diff = i_now - i_first;
    assign w_reply_diff = i_now - i_reply;
    assign w_ping_diff  = i_now - i_ping;
    assign w_bad        = (i_ctl.state == ST_BAD);

    always_comb begin
        if (!i_ctl.valid) begin
            // An absent peer answers with fixed values.
            o_result.present      = 1'b0;
            o_result.peer_state   = ST_UNKNOWN;
            o_result.missed_pings = '0;
            o_result.timed_out    = 1'b1;
            o_result.ping_due     = 1'b0;
            o_result.expired      = 1'b1;
            o_result.peer_age     = '0;
            o_result.reply_span   = '1;
            o_result.ping_span    = '1;
        end else begin
            o_result.present      = 1'b1;
            o_result.peer_state   = i_ctl.state;
            o_result.missed_pings = i_ctl.count;

            if (i_cfg.inactive_tmo == '0) begin
                o_result.timed_out = 1'b0;
            end else if (w_last == '0) begin
                o_result.timed_out = 1'b1;
            end else begin
                o_result.timed_out = f_elapsed(i_now, w_last, TW'(i_cfg.inactive_tmo));
            end

            if (w_bad) begin
                o_result.ping_due = 1'b0;
            end else if (i_ping == '0) begin
                o_result.ping_due = 1'b1;
            end else begin
                o_result.ping_due = f_elapsed(i_now, i_ping, TW'(i_cfg.dubious_tmo));
            end

            if (w_bad || w_last == '0) begin
                o_result.expired = 1'b1;
            end else begin
                o_result.expired = f_elapsed(i_now, w_last, TW'({i_cfg.good_tmo, 1'b0}));
            end

            // Ages read zero when time has run backward past a stamp.
            if (i_first == '0 || i_now < i_first) begin
                o_result.peer_age = '0;
            end else begin
                o_result.peer_age = TIME_W'(w_first_diff);
            end

            if (i_reply == '0) begin
                o_result.reply_span = '1;
            end else if (i_now >= i_reply) begin
                o_result.reply_span = AGE_W'(w_reply_diff);
            end else begin
                o_result.reply_span = '0;
            end

            if (i_ping == '0) begin
                o_result.ping_span = '1;
            end else if (i_now >= i_ping) begin
                o_result.ping_span = AGE_W'(w_ping_diff);
            end else begin
                o_result.ping_span = '0;
            end
        end
    end

endmodule

// File: src/peer_liveness_tracker_core.sv
// An input beat is held in the input register until the result slot is free; its result is then
// registered and offered on the master side. Throughput: one beat per cycle unless the master
// side stalls; the record update is a loop from the record registers through the command logic
// back into them. The input register takes a new beat while a result waits, as long as it drains.
// Reset (i_rst_n low, synchronous) drops the peer record, empties both pipeline
// registers and loads the configuration registers with their default values.
module peer_liveness_tracker_core import plt_pkg::*; #(
    parameter int TIME_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [3:0] cmd, [43:4] now_seconds, [45:44] forced_state, [47:46] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] present, [2:1] peer_state, [10:3] missed_pings, [11] timed_out,
    // [12] ping_due, [13] expired, [53:14] peer_age, [94:54] reply_span,
    // [135:95] ping_span
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

    t_cfg          r_cfg;
    t_item         r_item;
    logic          r_in_valid;
    t_result       r_result;
    logic          r_out_valid;
    logic          w_fire;
    logic          w_in_take;
    logic [TW-1:0] w_now;
    t_peer_ctl     w_ctl;
    logic [TW-1:0] w_first;
    logic [TW-1:0] w_seen;
    logic [TW-1:0] w_reply;
    logic [TW-1:0] w_ping;
    t_result       w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_missed   <= MAX_MISSED_RST;
            r_cfg.dubious_tmo  <= DUBIOUS_TMO_RST;
            r_cfg.good_tmo     <= GOOD_TMO_RST;
            r_cfg.inactive_tmo <= INACTIVE_TMO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_MISSED:   r_cfg.max_missed   <= i_cfg_wdata[COUNT_W-1:0];
                CFG_DUBIOUS_TMO:  r_cfg.dubious_tmo  <= i_cfg_wdata[TMO_W-1:0];
                CFG_GOOD_TMO:     r_cfg.good_tmo     <= i_cfg_wdata[TMO_W-1:0];
                CFG_INACTIVE_TMO: r_cfg.inactive_tmo <= i_cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the item in the input register is processed when the result slot frees up.
    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item <= i_s_axis_tdata;
        end
    end

    assign w_now = r_item.now_seconds[TW-1:0];

    plt_state #(
        .TW (TW)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_cmd        (r_item.cmd),
        .i_now        (w_now),
        .i_forced     (r_item.forced_state),
        .i_max_missed (r_cfg.max_missed),
        .o_ctl        (w_ctl),
        .o_first      (w_first),
        .o_seen       (w_seen),
        .o_reply      (w_reply),
        .o_ping       (w_ping)
    );

    plt_report #(
        .TW (TW)
    ) u_report (
        .i_ctl    (w_ctl),
        .i_first  (w_first),
        .i_seen   (w_seen),
        .i_reply  (w_reply),
        .i_ping   (w_ping),
        .i_now    (w_now),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

endmodule

// File: src/plt_checker.sv
module plt_checker import plt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_result w_res;

    assign w_res = o_m_axis_tdata;

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline and opens the slave side.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

    // An absent peer reports its fixed answer.
    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_res.present |->
            w_res.peer_state == ST_UNKNOWN && w_res.missed_pings == '0 &&
            w_res.timed_out && !w_res.ping_due && w_res.expired &&
            w_res.peer_age == '0 && w_res.reply_span == '1 && w_res.ping_span == '1)
        else $error("absent peer result malformed");

    // A bad peer is always expired and never due for a ping.
    a_bad_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.present && w_res.peer_state == ST_BAD |->
            w_res.expired && !w_res.ping_due)
        else $error("bad peer flags inconsistent");

endmodule

bind peer_liveness_tracker_core plt_checker u_plt_checker (.*);
